>>> hdl/b64dd_pkg.sv
// Shared types, constants and helpers for the binary64 exact decimal digit converter.
// Used by b64dd_ctrl, b64dd_dp and binary64_exact_decimal_digits; depends on nothing.
package b64dd_pkg;

  localparam int LIMB_COUNT_MAX_DEF  = 192;
  localparam int DIGIT_CAPACITY_DEF  = 768;
  localparam int DIGITS_PER_WORD_DEF = 16;

  localparam int RAW_W     = 64;
  localparam int WORD_W    = 64;
  localparam int WIDX_W    = 6;
  localparam int DCNT_W    = 10;
  localparam int SHIFT_W   = 12;
  localparam int MAX_WORDS = 48;
  localparam int LIMB_W    = 14;
  localparam int FAC_W     = 19;
  localparam int PROD_W    = 32;
  localparam int POW_W     = 11;
  localparam int BITCNT_W  = 6;
  localparam int SIG_W     = 53;
  localparam int OUT_DATA_W = 96;

  localparam logic [PROD_W-1:0] LIMB_BASE = PROD_W'(10000);
  localparam logic [FAC_W-1:0]  FAC_CHUNK2 = FAC_W'(262144);
  localparam logic [FAC_W-1:0]  FAC_CHUNK5 = FAC_W'(3125);
  localparam logic [FAC_W-1:0]  FAC_UNIT2  = FAC_W'(2);
  localparam logic [FAC_W-1:0]  FAC_UNIT5  = FAC_W'(5);
  localparam logic [POW_W-1:0]  LEN_CHUNK2 = POW_W'(18);
  localparam logic [POW_W-1:0]  LEN_CHUNK5 = POW_W'(5);
  localparam logic [10:0]       EXP_SPECIAL = 11'h7ff;

  // floor(p/10000) = floor((p>>4)/625), estimated low by at most one
  localparam int RECIP_SH = 38;
  localparam logic [28:0] RECIP_625 = 29'((64'd1 << RECIP_SH) / 625);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLASSIFY, ST_PASS_INIT, ST_CHK, ST_M_RD, ST_M_A, ST_M_B, ST_M_C,
    ST_PASS_END, ST_SCHED, ST_TOP_INIT, ST_D_RD, ST_D_S1, ST_D_S2, ST_D_USE,
    ST_TOP_CHK, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    JOB_TOP, JOB_TZ, JOB_EMIT
  } job_t;

  typedef struct packed {
    logic load_in;
    logic single_inv;
    logic single_zero;
    logic pass_start;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic pass_end;
    logic top_start;
    logic top_eval;
    logic tz_start;
    logic pos_inc;
    logic tz_done;
    logic emit_put;
    logic out_ack;
    logic rd_pos;
  } cmd_t;

  typedef struct packed {
    logic is_nan;
    logic is_zero;
    logic pass_more;
    logic ovf;
    logic work_left;
    logic total_over;
    logic tz_more;
    logic word_end;
    logic last;
  } sts_t;

  // two BCD digits of a value below 100
  function automatic logic [7:0] bcd99(input logic [6:0] v);
    logic [17:0] t;
    logic [3:0]  tens;
    logic [6:0]  ones;
    t    = 18'(v) * 18'd205;
    tens = t[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

>>> hdl/b64dd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module b64dd_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/b64dd_ctrl.sv
// Sequencer for the converter: load, scaling passes, digit scan and word output.
// Depends on b64dd_pkg; drives b64dd_dp through cmd_t and reads sts_t.
module b64dd_ctrl
  import b64dd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);

  state_t state, state_next;
  job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_TOP;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CLASSIFY;
      ST_CLASSIFY: begin
        if (sts.is_nan || sts.is_zero) state_next = ST_OUT;
        else state_next = ST_PASS_INIT;
      end
      ST_PASS_INIT: state_next = ST_CHK;
      ST_CHK: begin
        if (sts.ovf) state_next = ST_OUT;
        else if (sts.pass_more) state_next = ST_M_RD;
        else state_next = ST_PASS_END;
      end
      ST_M_RD:      state_next = ST_M_A;
      ST_M_A:       state_next = ST_M_B;
      ST_M_B:       state_next = ST_M_C;
      ST_M_C:       state_next = ST_CHK;
      ST_PASS_END:  state_next = ST_SCHED;
      ST_SCHED: begin
        if (sts.work_left) state_next = ST_PASS_INIT;
        else state_next = ST_TOP_INIT;
      end
      ST_TOP_INIT: begin
        state_next = ST_D_RD;
        job_next   = JOB_TOP;
      end
      ST_D_RD:      state_next = ST_D_S1;
      ST_D_S1:      state_next = ST_D_S2;
      ST_D_S2:      state_next = ST_D_USE;
      ST_D_USE: begin
        case (job)
          JOB_TOP: state_next = ST_TOP_CHK;
          JOB_TZ: begin
            state_next = ST_D_RD;
            if (!sts.tz_more) job_next = JOB_EMIT;
          end
          JOB_EMIT: begin
            if (sts.word_end) state_next = ST_OUT;
            else state_next = ST_D_RD;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_TOP_CHK: begin
        if (sts.total_over) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_D_RD;
          job_next   = JOB_TZ;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (sts.last) state_next = ST_IDLE;
          else state_next = ST_D_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_CLASSIFY: begin
        cmd.single_inv  = sts.is_nan;
        cmd.single_zero = sts.is_zero && !sts.is_nan;
      end
      ST_PASS_INIT: cmd.pass_start = 1'b1;
      ST_CHK:       cmd.single_inv = sts.ovf;
      ST_M_A:       cmd.mul_a = 1'b1;
      ST_M_B:       cmd.mul_b = 1'b1;
      ST_M_C:       cmd.mul_c = 1'b1;
      ST_PASS_END:  cmd.pass_end = 1'b1;
      ST_TOP_INIT:  cmd.top_start = 1'b1;
      ST_D_RD:      cmd.rd_pos = 1'b1;
      ST_D_USE: begin
        case (job)
          JOB_TOP:  cmd.top_eval = 1'b1;
          JOB_TZ: begin
            cmd.pos_inc = sts.tz_more;
            cmd.tz_done = !sts.tz_more;
          end
          JOB_EMIT: cmd.emit_put = 1'b1;
          default:  cmd = '0;
        endcase
      end
      ST_TOP_CHK: begin
        cmd.single_inv = sts.total_over;
        cmd.tz_start   = !sts.total_over;
      end
      ST_OUT: begin
        out_valid  = 1'b1;
        cmd.out_ack = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/b64dd_dp.sv
// Datapath: limb store, multiply-by-factor unit, BCD split, digit scan and word builder.
// Depends on b64dd_pkg and b64dd_ram; commanded by b64dd_ctrl.
module b64dd_dp
  import b64dd_pkg::*;
#(
  parameter int LIMB_COUNT_MAX  = LIMB_COUNT_MAX_DEF,
  parameter int DIGIT_CAPACITY  = DIGIT_CAPACITY_DEF,
  parameter int DIGITS_PER_WORD = DIGITS_PER_WORD_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [RAW_W-1:0]          raw_bits,
  output sts_t                      sts,
  output logic                      status,
  output logic [WORD_W-1:0]         digit_word,
  output logic [WIDX_W-1:0]         word_index,
  output logic [DCNT_W-1:0]         num_digits,
  output logic signed [SHIFT_W-1:0] ten_exp,
  output logic                      last
);

  localparam int ADDR_W = $clog2(LIMB_COUNT_MAX);
  localparam int CNT_W  = $clog2(LIMB_COUNT_MAX + 1);
  localparam int POS_W  = ADDR_W + 2;
  localparam int TOT_W  = $clog2(4 * LIMB_COUNT_MAX + 1);
  localparam int CAP    = (DIGIT_CAPACITY < MAX_WORDS * DIGITS_PER_WORD) ?
                          DIGIT_CAPACITY : MAX_WORDS * DIGITS_PER_WORD;
  localparam int SLOT_W = (DIGITS_PER_WORD > 1) ? $clog2(DIGITS_PER_WORD) : 1;

  logic [10:0]        exp_r;
  logic [SIG_W-1:0]   sig;
  logic [BITCNT_W-1:0] bitcnt;
  logic               neg;
  logic [POW_W-1:0]   power_left;
  logic [CNT_W-1:0]   limb_count;
  logic [CNT_W-1:0]   idx;
  logic [FAC_W-1:0]   carry;
  logic [PROD_W-1:0]  p;
  logic [56:0]        prod;
  logic [TOT_W-1:0]   total;
  logic [POS_W-1:0]   pos;
  logic [DCNT_W-1:0]  rem;
  logic [SLOT_W-1:0]  slot;
  logic [LIMB_W-1:0]  s1_x;
  logic [6:0]         s1_hq;
  logic [15:0]        bcd;

  logic [LIMB_W-1:0]  rdata;
  logic [ADDR_W-1:0]  raddr;
  logic [LIMB_W-1:0]  wdata;
  logic               we;

  logic [FAC_W-1:0]   factor;
  logic [POW_W-1:0]   flen;
  logic [LIMB_W-1:0]  limbval;
  logic [FAC_W-1:0]   q0;
  logic [PROD_W-1:0]  r1;
  logic               corr;
  logic               ext;
  logic [3:0]         digit;
  logic [2:0]         top_digits;
  logic [25:0]        hq_prod;
  logic [6:0]         lo;

  assign raddr = cmd.rd_pos ? pos[POS_W-1:2] : idx[ADDR_W-1:0];

  b64dd_ram #(.WIDTH(LIMB_W), .DEPTH(LIMB_COUNT_MAX)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (idx[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (bitcnt != '0) begin
      factor = FAC_UNIT2;
      flen   = POW_W'(1);
    end else if (neg) begin
      factor = (power_left >= LEN_CHUNK5) ? FAC_CHUNK5 : FAC_UNIT5;
      flen   = (power_left >= LEN_CHUNK5) ? LEN_CHUNK5 : POW_W'(1);
    end else begin
      factor = (power_left >= LEN_CHUNK2) ? FAC_CHUNK2 : FAC_UNIT2;
      flen   = (power_left >= LEN_CHUNK2) ? LEN_CHUNK2 : POW_W'(1);
    end
  end

  assign ext     = idx >= limb_count;
  assign limbval = ext ? '0 : rdata;
  assign q0      = prod[RECIP_SH +: FAC_W];
  assign r1      = p - PROD_W'(q0) * LIMB_BASE;
  assign corr    = r1 >= LIMB_BASE;
  assign wdata   = corr ? LIMB_W'(r1 - LIMB_BASE) : r1[LIMB_W-1:0];
  assign we      = cmd.mul_c;

  assign hq_prod = 26'(rdata) * 26'd5243;
  assign lo      = 7'(s1_x - LIMB_W'(s1_hq) * LIMB_W'(100));
  assign digit   = bcd[4*pos[1:0] +: 4];

  always_comb begin
    if (bcd[15:12] != 4'd0) top_digits = 3'd4;
    else if (bcd[11:8] != 4'd0) top_digits = 3'd3;
    else if (bcd[7:4] != 4'd0) top_digits = 3'd2;
    else top_digits = 3'd1;
  end

  always_comb begin
    sts            = '0;
    sts.is_nan     = exp_r == EXP_SPECIAL;
    sts.is_zero    = (exp_r == 11'd0) && (sig == '0);
    sts.pass_more  = !ext || (carry != '0);
    sts.ovf        = ext && (carry != '0) && (limb_count >= CNT_W'(LIMB_COUNT_MAX));
    sts.work_left  = (bitcnt != '0) || (power_left != '0);
    sts.total_over = total > TOT_W'(CAP);
    sts.tz_more    = (TOT_W'(pos) + TOT_W'(1) < total) && (digit == 4'd0);
    sts.word_end   = (slot == SLOT_W'(DIGITS_PER_WORD - 1)) || (rem == DCNT_W'(1));
    sts.last       = last;
  end

  always_ff @(posedge clk) begin
    s1_x  <= rdata;
    s1_hq <= hq_prod[19 +: 7];
    bcd   <= {bcd99(s1_hq), bcd99(lo)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limb_count <= '0;
      power_left <= '0;
      ten_exp <= '0;
      num_digits <= '0;
      bitcnt <= '0;
    end else begin
      if (cmd.load_in) begin
        exp_r      <= raw_bits[62:52];
        sig        <= {raw_bits[62:52] != 11'd0, raw_bits[51:0]};
        bitcnt     <= BITCNT_W'(SIG_W);
        limb_count <= '0;
        if (raw_bits[62:52] == 11'd0) begin
          neg        <= 1'b1;
          power_left <= POW_W'(1074);
          ten_exp <= -SHIFT_W'(1074);
        end else if (raw_bits[62:52] >= 11'd1075) begin
          neg        <= 1'b0;
          power_left <= raw_bits[62:52] - 11'd1075;
          ten_exp <= '0;
        end else begin
          neg        <= 1'b1;
          power_left <= 11'd1075 - raw_bits[62:52];
          ten_exp <= -SHIFT_W'(11'd1075 - raw_bits[62:52]);
        end
      end
      if (cmd.single_inv || cmd.single_zero) begin
        status        <= cmd.single_inv;
        digit_word    <= '0;
        word_index    <= '0;
        num_digits    <= cmd.single_inv ? DCNT_W'(0) : DCNT_W'(1);
        ten_exp       <= '0;
        last          <= 1'b1;
      end
      if (cmd.pass_start) begin
        idx   <= '0;
        carry <= (bitcnt != '0) ? FAC_W'(sig[SIG_W-1]) : '0;
      end
      if (cmd.mul_a) p <= PROD_W'(limbval) * PROD_W'(factor) + PROD_W'(carry);
      if (cmd.mul_b) prod <= 57'(p[PROD_W-1:4]) * 57'(RECIP_625);
      if (cmd.mul_c) begin
        carry <= q0 + FAC_W'(corr);
        idx   <= idx + CNT_W'(1);
        if (ext) limb_count <= limb_count + CNT_W'(1);
      end
      if (cmd.pass_end) begin
        if (bitcnt != '0) begin
          sig    <= {sig[SIG_W-2:0], 1'b0};
          bitcnt <= bitcnt - BITCNT_W'(1);
        end else begin
          power_left <= power_left - flen;
        end
      end
      if (cmd.top_start) pos <= {ADDR_W'(limb_count - CNT_W'(1)), 2'b00};
      if (cmd.top_eval) begin
        total <= TOT_W'(top_digits) + TOT_W'(pos);
      end
      if (cmd.tz_start) pos <= '0;
      if (cmd.pos_inc) pos <= pos + POS_W'(1);
      if (cmd.tz_done) begin
        status        <= 1'b0;
        last          <= 1'b0;
        digit_word    <= '0;
        word_index    <= '0;
        slot          <= '0;
        num_digits    <= DCNT_W'(total - TOT_W'(pos));
        rem           <= DCNT_W'(total - TOT_W'(pos));
        ten_exp       <= ten_exp + SHIFT_W'(pos);
        pos           <= POS_W'(total - TOT_W'(1));
      end
      if (cmd.emit_put) begin
        digit_word[WORD_W-1-4*slot -: 4] <= digit;
        pos  <= pos - POS_W'(1);
        rem  <= rem - DCNT_W'(1);
        slot <= slot + SLOT_W'(1);
        last <= rem == DCNT_W'(1);
      end
      if (cmd.out_ack) begin
        digit_word <= '0;
        slot       <= '0;
        word_index <= word_index + WIDX_W'(1);
      end
    end
  end

endmodule

>>> hdl/binary64_exact_decimal_digits.sv
// Exact decimal digits of a binary64 magnitude, 16-digit BCD words, most significant first.
// Each scaling pass walks every limb: 53 load passes, then e/18 + e%18 or
// (-e)/5 + (-e)%5 passes over up to 192 limbs, then a scan of the digits one by one.
// Zero, NaN or infinity skip the scaling passes and give one single-word result.
// One conversion at a time; next transaction accepted in idle after the last result is taken.
// Synchronous active-high reset returns to idle; the limb store itself is not cleared.
module binary64_exact_decimal_digits
  import b64dd_pkg::*;
#(
  parameter int LIMB_COUNT_MAX  = LIMB_COUNT_MAX_DEF,
  parameter int DIGIT_CAPACITY  = DIGIT_CAPACITY_DEF,
  parameter int DIGITS_PER_WORD = DIGITS_PER_WORD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [RAW_W-1:0]      s_tdata,   // raw_bits
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // digit_word, word_index, num_digits, ten_exp
  output logic                  m_tuser,   // status
  output logic                  m_tlast    // last
);

  cmd_t cmd;
  sts_t sts;
  logic [WORD_W-1:0]         digit_word;
  logic [WIDX_W-1:0]         word_index;
  logic [DCNT_W-1:0]         num_digits;
  logic signed [SHIFT_W-1:0] ten_exp;

  b64dd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  b64dd_dp #(
    .LIMB_COUNT_MAX  (LIMB_COUNT_MAX),
    .DIGIT_CAPACITY  (DIGIT_CAPACITY),
    .DIGITS_PER_WORD (DIGITS_PER_WORD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .raw_bits      (s_tdata),
    .sts           (sts),
    .status        (m_tuser),
    .digit_word    (digit_word),
    .word_index    (word_index),
    .num_digits    (num_digits),
    .ten_exp       (ten_exp),
    .last          (m_tlast)
  );

  assign m_tdata = {4'd0, ten_exp, num_digits, word_index, digit_word};

  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken while a result is pending");

  a_invalid_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[79:70] == 10'd0 && m_tdata[69:64] == 6'd0))
    else $error("invalid result not a single empty transaction");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[69:64] < 6'(MAX_WORDS))) else $error("word index out of range");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tdata[69:64] == $past(m_tdata[69:64]) + 6'd1))
    else $error("word index did not advance");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for binary64_exact_decimal_digits: drives binary64 patterns and
// checks every BCD digit word against a bignum digit expansion kept in the testbench.
// Depends on b64dd_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb_top;
  import b64dd_pkg::*;

  typedef struct {
    bit              status;
    bit [63:0]       word;
    bit [5:0]        idx;
    bit [9:0]        count;
    bit [11:0]       shift;
    bit              last;
  } digit_word_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [RAW_W-1:0]      s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  bit [63:0]     raw_queue[$];
  digit_word_t   digit_words_due[$];
  int            mismatches;
  int            words_seen;
  int            send_gap;
  int            recv_gap;
  int            hold_left;
  bit            hold_done;

  // bignum copy of the converter state
  int unsigned   limbs[LIMB_COUNT_MAX_DEF];
  int            limb_total;

  binary64_exact_decimal_digits dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit scale_limbs(int unsigned factor);
    longint unsigned p;
    longint unsigned carry;
    carry = 0;
    for (int i = 0; i < limb_total; i++) begin
      p = longint'(limbs[i]) * factor + carry;
      limbs[i] = 32'(p % 10000);
      carry = p / 10000;
    end
    while (carry != 0) begin
      if (limb_total >= LIMB_COUNT_MAX_DEF) return 1'b0;
      limbs[limb_total] = 32'(carry % 10000);
      carry = carry / 10000;
      limb_total++;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned decimal_digit(int unsigned pos);
    int unsigned v;
    if (pos / 4 >= limb_total) return 0;
    v = limbs[pos / 4];
    for (int k = 0; k < pos % 4; k++) v = v / 10;
    return v % 10;
  endfunction

  function automatic void push_single(bit status, bit [9:0] count);
    digit_word_t r;
    r = '{status, 64'd0, 6'd0, count, 12'd0, 1'b1};
    digit_words_due.push_back(r);
  endfunction

  function automatic void expand_binary64(bit [63:0] bits);
    bit [10:0]       exp_field;
    longint unsigned sig;
    int              bin_pow;
    int unsigned     power;
    int unsigned     chunk;
    int unsigned     chunk_len;
    int unsigned     unit;
    int unsigned     top;
    int unsigned     total;
    int unsigned     tz;
    int unsigned     kept;
    int unsigned     words;
    int              shift;
    digit_word_t     r;
    exp_field = bits[62:52];
    sig = 64'(bits[51:0]);
    if (exp_field == EXP_SPECIAL) begin
      push_single(1'b1, 10'd0);
      return;
    end
    if (bits[62:0] == 63'd0) begin
      push_single(1'b0, 10'd1);
      return;
    end
    if (exp_field == 0) bin_pow = -1074;
    else begin
      sig = sig | 64'h0010_0000_0000_0000;
      bin_pow = int'(exp_field) - 1075;
    end
    limb_total = 0;
    while (sig != 0) begin
      limbs[limb_total] = 32'(sig % 10000);
      sig = sig / 10000;
      limb_total++;
    end
    if (bin_pow >= 0) begin
      power = bin_pow; shift = 0; chunk = 262144; chunk_len = 18; unit = 2;
    end else begin
      power = -bin_pow; shift = bin_pow; chunk = 3125; chunk_len = 5; unit = 5;
    end
    while (power >= chunk_len) begin
      if (!scale_limbs(chunk)) begin push_single(1'b1, 10'd0); return; end
      power -= chunk_len;
    end
    while (power != 0) begin
      if (!scale_limbs(unit)) begin push_single(1'b1, 10'd0); return; end
      power--;
    end
    top = limbs[limb_total - 1];
    total = (top >= 1000 ? 4 : top >= 100 ? 3 : top >= 10 ? 2 : 1) + 4 * (limb_total - 1);
    if (total > MAX_WORDS * DIGITS_PER_WORD_DEF || total > DIGIT_CAPACITY_DEF) begin
      push_single(1'b1, 10'd0);
      return;
    end
    tz = 0;
    while (tz + 1 < total && decimal_digit(tz) == 0) tz++;
    kept = total - tz;
    shift += tz;
    words = (kept + DIGITS_PER_WORD_DEF - 1) / DIGITS_PER_WORD_DEF;
    for (int w = 0; w < words; w++) begin
      r.word = '0;
      for (int i = 0; i < DIGITS_PER_WORD_DEF; i++)
        if (w * DIGITS_PER_WORD_DEF + i < kept)
          r.word[60 - 4 * i +: 4] =
            4'(decimal_digit(total - 1 - (w * DIGITS_PER_WORD_DEF + i)));
      r.status = 1'b0;
      r.idx = 6'(w);
      r.count = 10'(kept);
      r.shift = 12'(shift);
      r.last = (w + 1 == words);
      digit_words_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (raw_queue.size() > 0) begin
        s_tdata  <= raw_queue.pop_front();
        s_tvalid <= 1'b1;
        if (raw_queue.size() > 15 && $urandom_range(0, 3) == 0)
          send_gap <= $urandom_range(1, 5);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long hold-off on the result side once, so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_seen >= 5) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (raw_queue.size() > 15 && $urandom_range(0, 3) == 0)
        recv_gap <= $urandom_range(1, 5);
    end
  end

  // monitor
  always @(posedge clk) begin
    digit_word_t r;
    if (!rst) begin
      if (s_tvalid && s_tready) expand_binary64(s_tdata);
      if (m_tvalid && m_tready) begin
        words_seen <= words_seen + 1;
        if (digit_words_due.size() == 0) begin
          report_mismatch("unexpected transaction", m_tdata[63:0], 0);
        end else begin
          r = digit_words_due.pop_front();
          if (m_tuser !== r.status) report_mismatch("status", m_tuser, r.status);
          if (m_tdata[63:0] !== r.word) report_mismatch("digit_word", m_tdata[63:0], r.word);
          if (m_tdata[69:64] !== r.idx) report_mismatch("word_index", m_tdata[69:64], r.idx);
          if (m_tdata[79:70] !== r.count)
            report_mismatch("num_digits", m_tdata[79:70], r.count);
          if (m_tdata[91:80] !== r.shift)
            report_mismatch("ten_exp", m_tdata[91:80], r.shift);
          if (m_tlast !== r.last) report_mismatch("last", m_tlast, r.last);
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit [10:0] e;
    int        pick;
    mismatches = 0;
    words_seen = 0;
    rst = 1'b1;
    raw_queue = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
      64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001, 64'hffff_ffff_ffff_ffff,
      64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff, 64'h0010_0000_0000_0000,
      64'h001f_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000,
      64'h3fe0_0000_0000_0000, 64'h4330_0000_0000_0000, 64'h4340_0000_0000_0000,
      64'h44b5_2d02_c7e1_4af6, 64'h4059_0000_0000_0000, 64'h3fb9_9999_9999_999a,
      64'h7fef_ffff_ffff_ffff, 64'h4024_0000_0000_0000, 64'h8000_0000_0000_0001
    };
    for (int n = 0; n < 100; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) e = 11'($urandom_range(1023 - 30, 1023 + 80));
      else if (pick == 16) e = $urandom_range(0, 1) ? 11'd0 : EXP_SPECIAL;
      else e = 11'($urandom_range(0, 2046));
      raw_queue.push_back({1'($urandom), e, 20'($urandom), 32'($urandom)});
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (raw_queue.size() == 0 && !s_tvalid);
    wait (digit_words_due.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digit_words_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/b64dd_pkg.sv
hdl/b64dd_ram.sv
hdl/b64dd_ctrl.sv
hdl/b64dd_dp.sv
hdl/binary64_exact_decimal_digits.sv
dv/tb_top.sv
